// ----- design/mkseg_pkg.sv -----
package mkseg_pkg;

    // Payload words
    typedef struct packed {
        logic       command;
        logic [7:0] character;
    } in_word_t;

    typedef struct packed {
        logic        key_level;
        logic [17:0] duration_ticks;
        logic        last_segment;
    } out_word_t;

    localparam logic [15:0] DOT_TICKS_RESET = 16'd500;
    localparam logic        CMD_END = 1'b1;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_A = 8'h41;
    localparam logic [7:0]  CHAR_Z = 8'h5A;
    localparam logic [7:0]  CHAR_0 = 8'h30;
    localparam logic [7:0]  CHAR_9 = 8'h39;
    localparam int unsigned MAX_ELEM = 5;

    // Morse tables: element count and element bits, first element in bit (count-1),
    // a one is a dash
    localparam logic [2:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [4:0] LETTER_BITS [26] = '{
        5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4, 5'd3,
        5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12
    };
    localparam logic [4:0] DIGIT_BITS [10] = '{
        5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
    };

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;
    } morse_code_t;

    // Look up a character, elements left-aligned to bit 4
    function automatic morse_code_t morse_lookup(input logic [7:0] ch);
        morse_code_t code;
        logic [7:0] idx;
        code.len = 3'd0;
        code.bits = 5'd0;
        idx = 8'd0;
        if (ch inside {[CHAR_A:CHAR_Z]}) begin
            idx = ch - CHAR_A;
            code.len = LETTER_LEN[idx[4:0]];
            code.bits = LETTER_BITS[idx[4:0]] << (3'(MAX_ELEM) - LETTER_LEN[idx[4:0]]);
        end else if (ch inside {[CHAR_0:CHAR_9]}) begin
            idx = ch - CHAR_0;
            code.len = 3'(MAX_ELEM);
            code.bits = DIGIT_BITS[idx[3:0]];
        end
        return code;
    endfunction

    // Microcode
    localparam logic [1:0] MUL_ONE  = 2'd0;
    localparam logic [1:0] MUL_TWO  = 2'd1;
    localparam logic [1:0] MUL_FOUR = 2'd2;
    localparam logic [1:0] MUL_DASH = 2'd3;

    localparam logic [2:0] COND_NEVER  = 3'd0;
    localparam logic [2:0] COND_ALWAYS = 3'd1;
    localparam logic [2:0] COND_NOIN   = 3'd2;
    localparam logic [2:0] COND_END    = 3'd3;
    localparam logic [2:0] COND_SPACE  = 3'd4;
    localparam logic [2:0] COND_NOELEM = 3'd5;
    localparam logic [2:0] COND_NOWORD = 3'd6;

    localparam logic [3:0] PC_WAIT   = 4'd0;
    localparam logic [3:0] PC_TEST_E = 4'd1;
    localparam logic [3:0] PC_TEST_S = 4'd2;
    localparam logic [3:0] PC_LOOP   = 4'd3;
    localparam logic [3:0] PC_MARK   = 4'd4;
    localparam logic [3:0] PC_SPACE  = 4'd5;
    localparam logic [3:0] PC_GAP    = 4'd6;
    localparam logic [3:0] PC_WSPACE = 4'd7;
    localparam logic [3:0] PC_EOM    = 4'd8;
    localparam logic [3:0] PC_EGAP   = 4'd9;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic       level;
        logic [1:0] mul_sel;
        logic       last;
        logic       word_set;
        logic       word_clr;
        logic       shift;
        logic [2:0] cond;
        logic [3:0] target;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t cw;
        logic       fire;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic is_end;
        logic is_space;
        logic no_elem;
        logic word_open;
    } status_t;

    function automatic ctrl_word_t ucode_rom(input logic [3:0] pc);
        ctrl_word_t w;
        w = '{accept: 1'b0, emit: 1'b0, level: 1'b0, mul_sel: MUL_ONE, last: 1'b0,
              word_set: 1'b0, word_clr: 1'b0, shift: 1'b0, cond: COND_ALWAYS,
              target: PC_WAIT};
        case (pc)
            PC_WAIT: begin
                w.accept = 1'b1;
                w.cond = COND_NOIN;
                w.target = PC_WAIT;
            end
            PC_TEST_E: begin
                w.cond = COND_END;
                w.target = PC_EOM;
            end
            PC_TEST_S: begin
                w.cond = COND_SPACE;
                w.target = PC_WSPACE;
            end
            PC_LOOP: begin
                w.cond = COND_NOELEM;
                w.target = PC_GAP;
            end
            PC_MARK: begin
                w.emit = 1'b1;
                w.level = 1'b1;
                w.mul_sel = MUL_DASH;
                w.cond = COND_NEVER;
            end
            PC_SPACE: begin
                w.emit = 1'b1;
                w.shift = 1'b1;
                w.target = PC_LOOP;
            end
            PC_GAP: begin
                w.emit = 1'b1;
                w.mul_sel = MUL_TWO;
                w.last = 1'b1;
                w.word_set = 1'b1;
            end
            PC_WSPACE: begin
                w.emit = 1'b1;
                w.mul_sel = MUL_FOUR;
                w.last = 1'b1;
                w.word_clr = 1'b1;
            end
            PC_EOM: begin
                w.cond = COND_NOWORD;
                w.target = PC_WAIT;
            end
            PC_EGAP: begin
                w.emit = 1'b1;
                w.mul_sel = MUL_FOUR;
                w.last = 1'b1;
                w.word_clr = 1'b1;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/morse_keyer_segment_gen.sv -----
// Channel  Ports                          Word
// input    s_valid s_ready s_data         command, character
// output   m_valid m_ready m_data         key_level, duration_ticks, last_segment
// config   cfg_we cfg_wdata               dot_ticks
//
// One word at a time runs through the microcode step counter, one step a cycle
// while no emit step stalls. A letter or digit sends a mark and a space per element,
// then a gap; an end of message sends a gap only if a word is open.
// Reset is synchronous, active low; dot_ticks comes up as 500 and no word is open.
// An emit step holds while the output register is full and not taken.
module morse_keyer_segment_gen (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mkseg_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mkseg_pkg::out_word_t m_data
);

    mkseg_pkg::ctrl_t   ctrl;
    mkseg_pkg::status_t status;

    assign s_ready = ctrl.cw.accept;

    mkseg_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    mkseg_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

// ----- design/mkseg_sequencer.sv -----
module mkseg_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  mkseg_pkg::status_t status,
    output mkseg_pkg::ctrl_t   ctrl
);

    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    mkseg_pkg::ctrl_word_t cw;
    logic stall;
    logic taken;

    // Fetch and branch
    always_comb begin
        cw = mkseg_pkg::ucode_rom(pc_reg);
        stall = cw.emit && !status.out_free;
        case (cw.cond)
            mkseg_pkg::COND_NEVER:  taken = 1'b0;
            mkseg_pkg::COND_ALWAYS: taken = 1'b1;
            mkseg_pkg::COND_NOIN:   taken = !status.in_valid;
            mkseg_pkg::COND_END:    taken = status.is_end;
            mkseg_pkg::COND_SPACE:  taken = status.is_space;
            mkseg_pkg::COND_NOELEM: taken = status.no_elem;
            mkseg_pkg::COND_NOWORD: taken = !status.word_open;
            default:                taken = 1'b1;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
        ctrl.cw = cw;
        ctrl.fire = !stall;
    end

    // Advance the step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mkseg_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- design/mkseg_datapath.sv -----
module mkseg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    input  mkseg_pkg::in_word_t  s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output mkseg_pkg::out_word_t m_data,
    input  mkseg_pkg::ctrl_t     ctrl,
    output mkseg_pkg::status_t   status
);

    logic [15:0] dot_ticks_reg;
    logic        word_open_reg;
    logic        is_end_reg;
    logic        is_space_reg;
    logic [2:0]  len_reg;
    logic [4:0]  bits_reg;
    logic        m_valid_reg;
    mkseg_pkg::out_word_t m_data_reg;

    mkseg_pkg::morse_code_t code;
    logic        load;
    logic        emit;
    logic        out_free;
    logic [2:0]  mult;
    logic [17:0] duration;

    assign code = mkseg_pkg::morse_lookup(s_data.character);
    assign load = ctrl.cw.accept && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign emit = ctrl.cw.emit && ctrl.fire;

    // Pick the dot multiple and scale the dot length
    always_comb begin
        case (ctrl.cw.mul_sel)
            mkseg_pkg::MUL_ONE:  mult = 3'd1;
            mkseg_pkg::MUL_TWO:  mult = 3'd2;
            mkseg_pkg::MUL_FOUR: mult = 3'd4;
            mkseg_pkg::MUL_DASH: mult = bits_reg[4] ? 3'd3 : 3'd1;
            default:             mult = 3'd1;
        endcase
        duration = 18'({2'b00, dot_ticks_reg} * {15'd0, mult});
    end

    // Config register and word state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_ticks_reg <= mkseg_pkg::DOT_TICKS_RESET;
            word_open_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dot_ticks_reg <= cfg_wdata;
            end
            if (ctrl.fire && ctrl.cw.word_set) begin
                word_open_reg <= 1'b1;
            end else if (ctrl.fire && ctrl.cw.word_clr) begin
                word_open_reg <= 1'b0;
            end
        end
    end

    // Latch the word and walk its elements
    always_ff @(posedge aclk) begin
        if (load) begin
            is_end_reg   <= (s_data.command == mkseg_pkg::CMD_END);
            is_space_reg <= (s_data.character == mkseg_pkg::CHAR_SPACE);
            len_reg      <= code.len;
            bits_reg     <= code.bits;
        end else if (ctrl.fire && ctrl.cw.shift) begin
            len_reg  <= len_reg - 3'd1;
            bits_reg <= {bits_reg[3:0], 1'b0};
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.key_level      <= ctrl.cw.level;
            m_data_reg.duration_ticks <= duration;
            m_data_reg.last_segment   <= ctrl.cw.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assign status.in_valid  = s_valid;
    assign status.out_free  = out_free;
    assign status.is_end    = is_end_reg;
    assign status.is_space  = is_space_reg;
    assign status.no_elem   = (len_reg == 3'd0);
    assign status.word_open = word_open_reg;

endmodule
